### hw/rtl/panel_input_debounce_events_unit_assert.svh
// ----------------------------------------------------------------------------
// Panel input debounce events: assertion macros
// Clocked concurrent assertion helpers, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef PANEL_INPUT_DEBOUNCE_EVENTS_UNIT_ASSERT_SVH
`define PANEL_INPUT_DEBOUNCE_EVENTS_UNIT_ASSERT_SVH

// same-cycle implication
`define PIDE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PIDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// invariant
`define PIDE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

### hw/rtl/pide_pkg.sv
// ----------------------------------------------------------------------------
// pide_pkg
// Shared constants and types of the panel input debounce events unit.
// ----------------------------------------------------------------------------
package pide_pkg;

    localparam int POSITION_BITS = 16;
    localparam int KEY_BITS      = 8;
    localparam int SWITCH_BITS   = 4;
    localparam int SWITCH_POS_BITS = 3;
    localparam int BUTTON_DEPTH  = 4;
    localparam int KEY_DEPTH     = 4;
    localparam int SWITCH_DEPTH  = 4;

    localparam logic [SWITCH_BITS-1:0] SWITCH_MAX = 4'd5;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_MOVE   = 3'd1,
        EV_BUTTON = 3'd2,
        EV_KEY    = 3'd3,
        EV_SWITCH = 3'd4
    } event_kind_t;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

endpackage

### hw/rtl/panel_input_debounce_events_unit.sv
// ----------------------------------------------------------------------------
// panel_input_debounce_events_unit
// Debounces panel inputs on sample transactions and reports one change event
// per read transaction.
// ----------------------------------------------------------------------------
// One transaction per cycle unless in_stall is high: a sample updates the
// debounce histories and current values at the edge it is accepted; a read
// loads its event into the output register at the edge it is accepted. The
// input side stalls only while a finished event waits in the output register.
// Button, key and switch change after four equal samples in a row; the switch
// takes only positions 0 to 5. A read reports the highest-ranked change since
// the previous read (position, button, key, switch) and drops lower-ranked changes seen at the same time.
// ----------------------------------------------------------------------------
`include "panel_input_debounce_events_unit_assert.svh"

module panel_input_debounce_events_unit
    import pide_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [POSITION_BITS-1:0]   enc_position,
    input  logic                       raw_button,
    input  logic [KEY_BITS-1:0]        raw_key,
    input  logic [SWITCH_BITS-1:0]     raw_switch,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 event_kind,
    output logic [POSITION_BITS-1:0]   event_position,
    output logic                       event_pressed,
    output logic [KEY_BITS-1:0]        event_key,
    output logic [SWITCH_POS_BITS-1:0] event_switch
);

    logic [BUTTON_DEPTH-1:0]             button_hist_reg, button_hist_next;
    logic [KEY_DEPTH*KEY_BITS-1:0]       key_hist_reg, key_hist_next;
    logic [SWITCH_DEPTH*SWITCH_BITS-1:0] switch_hist_reg, switch_hist_next;

    logic [POSITION_BITS-1:0]   cur_position_reg, cur_position_next;
    logic                       cur_pressed_reg, cur_pressed_next;
    logic [KEY_BITS-1:0]        cur_key_reg, cur_key_next;
    logic [SWITCH_POS_BITS-1:0] cur_switch_reg, cur_switch_next;

    logic [POSITION_BITS-1:0]   last_position_reg;
    logic                       last_pressed_reg;
    logic [KEY_BITS-1:0]        last_key_reg;
    logic [SWITCH_POS_BITS-1:0] last_switch_reg;

    logic                       out_valid_reg, out_valid_next;
    event_kind_t                kind_reg, kind_next;
    logic [POSITION_BITS-1:0]   position_reg;
    logic                       pressed_reg;
    logic [KEY_BITS-1:0]        key_reg;
    logic [SWITCH_POS_BITS-1:0] switch_reg;

    logic in_accept;
    logic out_free;
    logic do_sample;
    logic do_read;
    logic key_equal;
    logic switch_equal;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !out_free;
    assign in_accept = in_valid && !in_stall;
    assign do_sample = in_accept && (action_t'(action) == ACT_SAMPLE);
    assign do_read   = in_accept && (action_t'(action) == ACT_READ);

    always_comb
    begin
        button_hist_next = {button_hist_reg[BUTTON_DEPTH-2:0], raw_button};
        key_hist_next    = {key_hist_reg[(KEY_DEPTH-1)*KEY_BITS-1:0], raw_key};
        switch_hist_next = {switch_hist_reg[(SWITCH_DEPTH-1)*SWITCH_BITS-1:0], raw_switch};

        key_equal = 1'b1;
        for (int i = 1; i < KEY_DEPTH; i++)
        begin
            if (key_hist_next[i*KEY_BITS +: KEY_BITS] != key_hist_next[KEY_BITS-1:0])
            begin
                key_equal = 1'b0;
            end
        end

        switch_equal = (switch_hist_next[SWITCH_BITS-1:0] <= SWITCH_MAX);
        for (int i = 1; i < SWITCH_DEPTH; i++)
        begin
            if (switch_hist_next[i*SWITCH_BITS +: SWITCH_BITS]
                != switch_hist_next[SWITCH_BITS-1:0])
            begin
                switch_equal = 1'b0;
            end
        end

        cur_position_next = enc_position;

        cur_pressed_next = cur_pressed_reg;
        if (&button_hist_next)
        begin
            cur_pressed_next = 1'b1;
        end
        else if (!(|button_hist_next))
        begin
            cur_pressed_next = 1'b0;
        end

        cur_key_next = key_equal ? key_hist_next[KEY_BITS-1:0] : cur_key_reg;
        cur_switch_next = switch_equal ? switch_hist_next[SWITCH_POS_BITS-1:0]
                                       : cur_switch_reg;
    end

    always_comb
    begin
        priority if (last_position_reg != cur_position_reg)
        begin
            kind_next = EV_MOVE;
        end
        else if (last_pressed_reg != cur_pressed_reg)
        begin
            kind_next = EV_BUTTON;
        end
        else if (last_key_reg != cur_key_reg)
        begin
            kind_next = EV_KEY;
        end
        else if (last_switch_reg != cur_switch_reg)
        begin
            kind_next = EV_SWITCH;
        end
        else
        begin
            kind_next = EV_NONE;
        end

        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = do_read;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_hist_reg   <= '0;
            key_hist_reg      <= '0;
            switch_hist_reg   <= '0;
            cur_position_reg  <= '0;
            cur_pressed_reg   <= 1'b0;
            cur_key_reg       <= '0;
            cur_switch_reg    <= '0;
            last_position_reg <= '0;
            last_pressed_reg  <= 1'b0;
            last_key_reg      <= '0;
            last_switch_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (do_sample)
            begin
                button_hist_reg  <= button_hist_next;
                key_hist_reg     <= key_hist_next;
                switch_hist_reg  <= switch_hist_next;
                cur_position_reg <= cur_position_next;
                cur_pressed_reg  <= cur_pressed_next;
                cur_key_reg      <= cur_key_next;
                cur_switch_reg   <= cur_switch_next;
            end
            if (do_read)
            begin
                last_position_reg <= cur_position_reg;
                last_pressed_reg  <= cur_pressed_reg;
                last_key_reg      <= cur_key_reg;
                last_switch_reg   <= cur_switch_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            kind_reg     <= kind_next;
            position_reg <= cur_position_reg;
            pressed_reg  <= cur_pressed_reg;
            key_reg      <= cur_key_reg;
            switch_reg   <= cur_switch_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = kind_reg;
    assign event_position = position_reg;
    assign event_pressed  = pressed_reg;
    assign event_key      = key_reg;
    assign event_switch   = switch_reg;

    `PIDE_ASSERT_NEXT(a_read_gives_event, do_read, out_valid_reg)
    `PIDE_ASSERT_NEXT(a_sample_no_event, do_sample, !out_valid_reg)
    `PIDE_ASSERT_NEXT(a_read_syncs_last, do_read,
        (last_position_reg == cur_position_reg) && (last_pressed_reg == cur_pressed_reg)
        && (last_key_reg == cur_key_reg) && (last_switch_reg == cur_switch_reg))
    `PIDE_ASSERT_ALWAYS(a_switch_range, {1'b0, cur_switch_reg} <= SWITCH_MAX)
    `PIDE_ASSERT_SAME(a_event_switch_range, out_valid_reg, {1'b0, switch_reg} <= SWITCH_MAX)

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Panel input debounce events unit testbench
// Drives sample and read transactions with random gaps on the input side and
// random stall on the event side. Every sample updates a local copy of the
// debounce state; every read queues the expected event, which is compared
// field by field with the next event the block returns. Directed transactions
// run first, then random bursts of stable or noisy samples, and reads.
// ----------------------------------------------------------------------------
module testbench;
    import pide_pkg::*;

    localparam int RANDOM_END    = 1725;
    localparam int IDLE_LIMIT    = 1000;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        action_t                  act;
        logic [POSITION_BITS-1:0] position;
        logic                     button;
        logic [KEY_BITS-1:0]      key;
        logic [SWITCH_BITS-1:0]   sw;
    } panel_txn_t;

    typedef struct packed {
        event_kind_t                 kind;
        logic [POSITION_BITS-1:0]    position;
        logic                        pressed;
        logic [KEY_BITS-1:0]         key;
        logic [SWITCH_POS_BITS-1:0]  sw;
    } panel_event_t;

    typedef struct packed {
        panel_txn_t   txn;
        bit           typed;
        panel_event_t ev;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       action;
    logic [POSITION_BITS-1:0]   enc_position;
    logic                       raw_button;
    logic [KEY_BITS-1:0]        raw_key;
    logic [SWITCH_BITS-1:0]     raw_switch;
    logic                       out_valid;
    logic                       out_stall;
    logic [2:0]                 event_kind;
    logic [POSITION_BITS-1:0]   event_position;
    logic                       event_pressed;
    logic [KEY_BITS-1:0]        event_key;
    logic [SWITCH_POS_BITS-1:0] event_switch;

    // local debounce state
    logic [3:0]                 btn_shift;
    logic [31:0]                key_shift;
    logic [15:0]                sw_shift;
    logic [POSITION_BITS-1:0]   deb_position;
    logic                       deb_pressed;
    logic [KEY_BITS-1:0]        deb_key;
    logic [SWITCH_POS_BITS-1:0] deb_switch;
    logic [POSITION_BITS-1:0]   rd_position;
    logic                       rd_pressed;
    logic [KEY_BITS-1:0]        rd_key;
    logic [SWITCH_POS_BITS-1:0] rd_switch;

    panel_event_t pending_events[$];
    stim_row_t    stim_rows[$];
    panel_event_t expected_ev;

    int  mismatches;
    int  txn_count;
    int  read_count;
    int  kind_seen[5];
    int  idle_cycles;
    int  stall_left;
    bit  calm;

    panel_input_debounce_events_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .enc_position   (enc_position),
        .raw_button     (raw_button),
        .raw_key        (raw_key),
        .raw_switch     (raw_switch),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .event_position (event_position),
        .event_pressed  (event_pressed),
        .event_key      (event_key),
        .event_switch   (event_switch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic panel_txn_t pack_txn(action_t a, logic [POSITION_BITS-1:0] p,
                                            logic b, logic [KEY_BITS-1:0] k,
                                            logic [SWITCH_BITS-1:0] s);
        panel_txn_t t;
        t.act      = a;
        t.position = p;
        t.button   = b;
        t.key      = k;
        t.sw       = s;
        return t;
    endfunction

    task automatic debounce_sample(input panel_txn_t t);
        deb_position = t.position;
        btn_shift = {btn_shift[2:0], t.button};
        if (btn_shift == 4'hf)
            deb_pressed = 1'b1;
        else if (btn_shift == 4'h0)
            deb_pressed = 1'b0;
        key_shift = {key_shift[23:0], t.key};
        if (key_shift == {4{t.key}})
            deb_key = t.key;
        sw_shift = {sw_shift[11:0], t.sw};
        if (t.sw <= SWITCH_MAX && sw_shift == {4{t.sw}})
            deb_switch = t.sw[SWITCH_POS_BITS-1:0];
    endtask

    function automatic panel_event_t next_panel_event();
        panel_event_t ev;
        if (rd_position != deb_position)
            ev.kind = EV_MOVE;
        else if (rd_pressed != deb_pressed)
            ev.kind = EV_BUTTON;
        else if (rd_key != deb_key)
            ev.kind = EV_KEY;
        else if (rd_switch != deb_switch)
            ev.kind = EV_SWITCH;
        else
            ev.kind = EV_NONE;
        ev.position = deb_position;
        ev.pressed  = deb_pressed;
        ev.key      = deb_key;
        ev.sw       = deb_switch;
        rd_position = deb_position;
        rd_pressed  = deb_pressed;
        rd_key      = deb_key;
        rd_switch   = deb_switch;
        return ev;
    endfunction

    task automatic send_txn(input panel_txn_t t, input bit typed = 1'b0,
                            input panel_event_t typed_ev = '0);
        int gap;
        panel_event_t ev;
        gap = calm ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= t.act;
        enc_position <= t.position;
        raw_button   <= t.button;
        raw_key      <= t.key;
        raw_switch   <= t.sw;
        do
            @(posedge clk);
        while (in_stall);
        txn_count++;
        if (t.act == ACT_SAMPLE)
            debounce_sample(t);
        else
        begin
            read_count++;
            ev = next_panel_event();
            if (typed)
                ev = typed_ev;
            pending_events.push_back(ev);
        end
    endtask

    task automatic add_row(action_t a, logic [POSITION_BITS-1:0] p, logic b,
                           logic [KEY_BITS-1:0] k, logic [SWITCH_BITS-1:0] s,
                           bit typed, event_kind_t ek, logic [POSITION_BITS-1:0] ep,
                           logic epr, logic [KEY_BITS-1:0] ekey,
                           logic [SWITCH_POS_BITS-1:0] esw);
        stim_row_t r;
        r.txn         = pack_txn(a, p, b, k, s);
        r.typed       = typed;
        r.ev.kind     = ek;
        r.ev.position = ep;
        r.ev.pressed  = epr;
        r.ev.key      = ekey;
        r.ev.sw       = esw;
        stim_rows.push_back(r);
    endtask

    task automatic run_directed();
        // after reset nothing has changed
        add_row(ACT_READ, 16'h0000, 1'b0, 8'h00, 4'h0,
                1'b1, EV_NONE, 16'h0000, 1'b0, 8'h00, 3'd0);
        add_row(ACT_SAMPLE, 16'hffff, 1'b1, 8'hff, 4'hf, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        // position taken at once, the rest still settling
        add_row(ACT_READ, 16'h0000, 1'b0, 8'h00, 4'h0,
                1'b1, EV_MOVE, 16'hffff, 1'b0, 8'h00, 3'd0);
        repeat (3)
            add_row(ACT_SAMPLE, 16'hffff, 1'b1, 8'hff, 4'h5, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        // button and key settle together, key change is dropped
        add_row(ACT_READ, 16'h0000, 1'b0, 8'h00, 4'h0,
                1'b1, EV_BUTTON, 16'hffff, 1'b1, 8'hff, 3'd0);
        add_row(ACT_SAMPLE, 16'hffff, 1'b1, 8'hff, 4'h5, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        add_row(ACT_READ, 16'h0000, 1'b0, 8'h00, 4'h0,
                1'b1, EV_SWITCH, 16'hffff, 1'b1, 8'hff, 3'd5);
        add_row(ACT_READ, 16'h0000, 1'b0, 8'h00, 4'h0,
                1'b1, EV_NONE, 16'hffff, 1'b1, 8'hff, 3'd5);
        // mixed button history holds the level
        add_row(ACT_SAMPLE, 16'hffff, 1'b0, 8'h00, 4'h3, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        add_row(ACT_SAMPLE, 16'hffff, 1'b1, 8'h00, 4'h3, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        add_row(ACT_SAMPLE, 16'hffff, 1'b0, 8'h00, 4'h3, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        add_row(ACT_SAMPLE, 16'hffff, 1'b0, 8'h00, 4'h3, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        add_row(ACT_READ,   16'h0000, 1'b0, 8'h00, 4'h0, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        // unequal key bytes and an invalid switch pattern hold old values
        add_row(ACT_SAMPLE, 16'h0000, 1'b0, 8'h5a, 4'hf, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        add_row(ACT_SAMPLE, 16'h0000, 1'b0, 8'h5a, 4'hf, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        add_row(ACT_SAMPLE, 16'h0000, 1'b0, 8'ha5, 4'hf, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        add_row(ACT_SAMPLE, 16'h0000, 1'b0, 8'h5a, 4'hf, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        add_row(ACT_READ,   16'h0000, 1'b0, 8'h00, 4'h0, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        repeat (4)
            add_row(ACT_SAMPLE, 16'h0000, 1'b0, 8'h5a, 4'h6, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        // raw fields of a read are ignored
        add_row(ACT_READ,   16'hffff, 1'b1, 8'hff, 4'hf, 1'b0, EV_NONE, '0, 1'b0, '0, '0);
        foreach (stim_rows[i])
            send_txn(stim_rows[i].txn, stim_rows[i].typed, stim_rows[i].ev);
    endtask

    task automatic run_random();
        int style;
        int n;
        logic [POSITION_BITS-1:0] pos_t;
        logic                     btn_t;
        logic [KEY_BITS-1:0]      key_t;
        logic [SWITCH_BITS-1:0]   sw_t;
        pos_t = '0;
        btn_t = 1'b0;
        key_t = '0;
        sw_t  = '0;
        while (txn_count < RANDOM_END)
        begin
            calm  = ($urandom_range(0, 4) == 0);
            style = $urandom_range(0, 9);
            if (style <= 6)
            begin
                if ($urandom_range(0, 2) == 0)
                    pos_t = 16'($urandom);
                if ($urandom_range(0, 2) == 0)
                    btn_t = ~btn_t;
                if ($urandom_range(0, 2) == 0)
                    key_t = 8'($urandom);
                if ($urandom_range(0, 2) == 0)
                    sw_t = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5));
                n = $urandom_range(3, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 5) == 0)
                        send_txn(pack_txn(ACT_SAMPLE, 16'($urandom), 1'($urandom),
                                          8'($urandom), 4'($urandom)));
                    else
                        send_txn(pack_txn(ACT_SAMPLE, pos_t, btn_t, key_t, sw_t));
                end
                n = $urandom_range(1, 2);
            end
            else if (style <= 8)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_txn(pack_txn(ACT_SAMPLE, 16'($urandom), 1'($urandom),
                                      8'($urandom), 4'($urandom)));
                n = $urandom_range(0, 1);
            end
            else
                n = $urandom_range(1, 3);
            repeat (n)
                send_txn(pack_txn(ACT_READ, 16'($urandom), 1'($urandom),
                                  8'($urandom), 4'($urandom)));
        end
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatches < REPORT_LIMIT)
            $display("mismatch: %s", msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            stall_left = calm ? 0 : $urandom_range(0, 4);
            if (pending_events.size() == 0)
                note_mismatch($sformatf("unexpected event kind %0d pos %h",
                                        event_kind, event_position));
            else
            begin
                expected_ev = pending_events.pop_front();
                kind_seen[expected_ev.kind]++;
                if (event_kind !== expected_ev.kind || event_position !== expected_ev.position
                    || event_pressed !== expected_ev.pressed || event_key !== expected_ev.key
                    || event_switch !== expected_ev.sw)
                    note_mismatch($sformatf(
                        "exp kind %0d pos %h pr %0d key %h sw %0d, got %0d %h %0d %h %0d",
                        expected_ev.kind, expected_ev.position, expected_ev.pressed,
                        expected_ev.key, expected_ev.sw, event_kind, event_position,
                        event_pressed, event_key, event_switch));
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_SAMPLE;
        enc_position = '0;
        raw_button   = 1'b0;
        raw_key      = '0;
        raw_switch   = '0;
        out_stall    = 1'b0;
        btn_shift    = '0;
        key_shift    = '0;
        sw_shift     = '0;
        deb_position = '0;
        deb_pressed  = 1'b0;
        deb_key      = '0;
        deb_switch   = '0;
        rd_position  = '0;
        rd_pressed   = 1'b0;
        rd_key       = '0;
        rd_switch    = '0;
        mismatches   = 0;
        txn_count    = 0;
        read_count   = 0;
        idle_cycles  = 0;
        stall_left   = 0;
        calm         = 1'b0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        @(negedge clk);
        in_valid <= 1'b0;
        calm = 1'b1;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
            note_mismatch($sformatf("%0d events never returned", pending_events.size()));

        $display("covered %0d transactions, %0d of them reads", txn_count, read_count);
        $display("events none %0d move %0d button %0d key %0d switch %0d",
                 kind_seen[EV_NONE], kind_seen[EV_MOVE], kind_seen[EV_BUTTON],
                 kind_seen[EV_KEY], kind_seen[EV_SWITCH]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
